/* sv/olia_pkg.sv */
package olia_pkg;

    localparam int POS_W        = 10;
    localparam int VAL_W        = 10;
    localparam int STAT_W       = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [STAT_W-1:0] {
        ST_ELEMENT = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

/* sv/olia_ram.sv */
module olia_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/ordered_list_insert_at_index.sv */
// Channel   Handshake            Payload
// --------  -------------------  ---------------------------------------
// command   start / busy         position, value
// result    strobe (one cycle)   status, direction, entry_value, last
//
// A rejected command (index beyond length or list full) gives its single
// result in the cycle after the transfer. A good insert moves each entry
// above the position up through SH_RD and SH_WR, ends the shift with a final
// SH_RD, writes the value in INS, then gives 2 * length results (length
// after the insert) on consecutive cycles, each registered from a read in
// EMIT, through the single read port of the entry memory.
// Reset empties the list at once; the memory itself is not cleared.
// The receiver cannot stall; busy is high until the last read is issued.
module ordered_list_insert_at_index
    import olia_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  value,
    output logic              strobe,
    output logic [STAT_W-1:0] status,
    output logic              direction,
    output logic [VAL_W-1:0]  entry_value,
    output logic              last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int KW = LW + 1;

    typedef enum logic [2:0] {
        IDLE,
        SH_RD,
        SH_WR,
        INS,
        EMIT
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     len_reg;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [KW-1:0]     k_reg;
    logic              valid_reg;
    status_t           status_reg;
    logic              dir_reg;
    logic              last_reg;
    logic              sel_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic [KW-1:0]     total;
    logic [KW-1:0]     rev;
    logic              fwd;
    logic              accept;

    assign accept = start && (state_reg == IDLE);
    assign total  = {len_reg, 1'b0};
    assign rev    = total - KW'(1) - k_reg;
    assign fwd    = k_reg < {1'b0, len_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg - AW'(1);
        case (state_reg)
            SH_RD:
            begin
                ram_re = (ptr_reg != pos_reg);
            end
            SH_WR:
            begin
                ram_we = 1'b1;
            end
            INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = val_reg;
            end
            EMIT:
            begin
                ram_re    = 1'b1;
                ram_raddr = fwd ? k_reg[AW-1:0] : rev[AW-1:0];
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    olia_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            len_reg    <= '0;
            valid_reg  <= 1'b0;
            status_reg <= ST_ELEMENT;
            dir_reg    <= 1'b0;
            last_reg   <= 1'b0;
            sel_reg    <= 1'b0;
            ptr_reg    <= '0;
            pos_reg    <= '0;
            val_reg    <= '0;
            k_reg      <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (position > POS_W'(len_reg))
                        begin
                            valid_reg  <= 1'b1;
                            status_reg <= ST_INVALID;
                            dir_reg    <= 1'b0;
                            last_reg   <= 1'b1;
                            sel_reg    <= 1'b0;
                        end
                        else if (len_reg == LW'(CAPACITY))
                        begin
                            valid_reg  <= 1'b1;
                            status_reg <= ST_FULL;
                            dir_reg    <= 1'b0;
                            last_reg   <= 1'b1;
                            sel_reg    <= 1'b0;
                        end
                        else
                        begin
                            ptr_reg   <= len_reg[AW-1:0];
                            pos_reg   <= position[AW-1:0];
                            val_reg   <= value;
                            state_reg <= SH_RD;
                        end
                    end
                end
                SH_RD:
                begin
                    state_reg <= (ptr_reg == pos_reg) ? INS : SH_WR;
                end
                SH_WR:
                begin
                    ptr_reg   <= ptr_reg - AW'(1);
                    state_reg <= SH_RD;
                end
                INS:
                begin
                    len_reg   <= len_reg + LW'(1);
                    k_reg     <= '0;
                    state_reg <= EMIT;
                end
                EMIT:
                begin
                    // Result data arrives from the memory in the cycle after the read.
                    valid_reg  <= 1'b1;
                    status_reg <= ST_ELEMENT;
                    dir_reg    <= !fwd;
                    last_reg   <= (rev == '0);
                    sel_reg    <= 1'b1;
                    k_reg      <= k_reg + KW'(1);
                    if (rev == '0)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != IDLE);
    assign strobe      = valid_reg;
    assign status      = status_reg;
    assign direction   = dir_reg;
    assign last        = last_reg;
    assign entry_value = sel_reg ? ram_rdata : '0;

endmodule

/* sv/olia_checker.sv */
module olia_checker
    import olia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  value,
    input  logic              strobe,
    input  logic [STAT_W-1:0] status,
    input  logic              direction,
    input  logic [VAL_W-1:0]  entry_value,
    input  logic              last
);

    // A rejected command yields exactly one result that carries no entry.
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_ELEMENT) |-> last && !direction && (entry_value == '0))
        else $error("rejected command result is malformed");

    // The results of one good insert come out on consecutive cycles.
    a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (status == ST_ELEMENT))
        else $error("gap inside a result burst");

    // Once the backward pass starts it runs to the end of the burst.
    a_backward_stays: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && direction && !last |=> strobe && direction)
        else $error("backward pass interrupted");

    // No new command is taken while a burst still has results to come.
    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("block idle in the middle of a result burst");

endmodule

bind ordered_list_insert_at_index olia_checker u_olia_checker (.*);
